/* hdl/dsed_pkg.sv */
// ----------------------------------------------------------------------------
// dsed_pkg
// Shared types and constants for the DLE/STX/ETX deframer: link symbols,
// result kind codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package dsed_pkg;

    // Link symbols
    localparam logic [7:0] SYM_STX = 8'h02;
    localparam logic [7:0] SYM_ETX = 8'h03;
    localparam logic [7:0] SYM_DLE = 8'h10;

    // Result kind codes, also used as command codes
    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_END      = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    // Length field wide enough for the largest supported frame depth (256)
    localparam int LEN_W = 9;

    // Command queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [LEN_W-1:0] length;
        logic [31:0]      count;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_SEND  = 3'b100
    } back_state_t;

endpackage

/* hdl/dle_stx_etx_deframer.sv */
// ----------------------------------------------------------------------------
// dle_stx_etx_deframer
// DLE/STX/ETX byte-stuffing deframer with a frame store and frame counter.
// ----------------------------------------------------------------------------
// Takes one link byte per word on the input channel. A frame opens with
// DLE STX (0x10 0x02) and closes with DLE ETX (0x10 0x03); DLE DLE is a
// literal 0x10 body byte and any other escape drops the open frame. Body
// bytes beyond FRAME_DEPTH drop the frame with one overflow result. A valid
// close bumps a wrapping 32-bit frame counter and, with emit_frames set and
// a body, sends the stored bytes (last one marked), else one end marker.
// Flow control: a byte that causes no result, an end marker or an overflow
// is taken while the command queue has room and no frame is draining. When
// a frame is emitted, input stalls until its N bytes have left the store:
// the back pops the command, then for each byte fetches it through the
// single registered read port of the frame store (FETCH state) and loads
// the output register (SEND state), waiting while the sink holds out_ready
// low. A two-word command queue lets the front keep taking bytes while end
// or overflow results wait at the output register. The store needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module dle_stx_etx_deframer #(
    parameter int FRAME_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        emit_frames_we,
    input  logic        emit_frames,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  frame_byte,
    output logic [3:0]  byte_index,
    output logic [4:0]  frame_length,
    output logic        last,
    output logic [31:0] frames_received
);

    localparam int AW = $clog2(FRAME_DEPTH);

    logic           emit_frames_reg;
    logic           store_we;
    logic [AW-1:0]  store_addr;
    logic [7:0]     store_data;
    logic           push;
    dsed_pkg::cmd_t push_data;
    logic           q_full;
    logic           q_valid;
    dsed_pkg::cmd_t q_data;
    logic           pop;
    logic           frame_done;

    // Config reg; user must write it only while block is idle; unchecked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_frames_reg <= 1'b0;
        end
        else if (emit_frames_we)
        begin
            emit_frames_reg <= emit_frames;
        end
    end

    // Front: decode escapes, fill the store, queue frame events
    dsed_front #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .emit_frames (emit_frames_reg),
        .store_we    (store_we),
        .store_addr  (store_addr),
        .store_data  (store_data),
        .push        (push),
        .push_data   (push_data),
        .q_full      (q_full),
        .frame_done  (frame_done)
    );

    // Queue: decouple event detection from result delivery
    dsed_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop)
    );

    // Back: drain the store or emit markers into the output register
    dsed_back #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .store_we        (store_we),
        .store_addr      (store_addr),
        .store_data      (store_data),
        .q_valid         (q_valid),
        .q_data          (q_data),
        .pop             (pop),
        .frame_done      (frame_done),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .frame_byte      (frame_byte),
        .byte_index      (byte_index),
        .frame_length    (frame_length),
        .last            (last),
        .frames_received (frames_received)
    );

endmodule

/* hdl/dsed_front.sv */
// ----------------------------------------------------------------------------
// dsed_front
// Accepts link bytes, tracks escape and frame state, writes body bytes into
// the frame store and queues one command per frame event.
// ----------------------------------------------------------------------------
module dsed_front #(
    parameter int FRAME_DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           in_byte,
    input  logic                                 emit_frames,
    output logic                                 store_we,
    output logic [$clog2(FRAME_DEPTH)-1:0]       store_addr,
    output logic [7:0]                           store_data,
    output logic                                 push,
    output dsed_pkg::cmd_t                       push_data,
    input  logic                                 q_full,
    input  logic                                 frame_done
);

    localparam int AW     = $clog2(FRAME_DEPTH);
    localparam int FILL_W = $clog2(FRAME_DEPTH + 1);

    logic              esc_reg, esc_next;
    logic              in_frame_reg, in_frame_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]       counter_reg, counter_next;
    logic              busy_reg, busy_next;
    logic              accept;
    logic              is_dle;
    logic              body;

    // Hold off input while the store is being drained or the queue is full
    assign in_ready = !q_full && !busy_reg;
    assign accept   = in_valid && in_ready;
    assign is_dle   = (in_byte == dsed_pkg::SYM_DLE);

    assign store_addr = fill_reg[AW-1:0];
    assign store_data = in_byte;

    always_comb
    begin
        esc_next         = esc_reg;
        in_frame_next    = in_frame_reg;
        fill_next        = fill_reg;
        counter_next     = counter_reg;
        busy_next        = busy_reg;
        store_we         = 1'b0;
        push             = 1'b0;
        push_data.kind   = dsed_pkg::KIND_END;
        push_data.length = dsed_pkg::LEN_W'(fill_reg);
        push_data.count  = counter_reg;
        body             = 1'b0;

        if (frame_done)
        begin
            busy_next = 1'b0;
        end

        if (accept)
        begin
            if (is_dle && !esc_reg)
            begin
                esc_next = 1'b1;
            end
            else if (esc_reg)
            begin
                esc_next = 1'b0;
                if (in_byte == dsed_pkg::SYM_STX)
                begin
                    in_frame_next = 1'b1;
                    fill_next     = '0;
                end
                else if (in_byte == dsed_pkg::SYM_ETX)
                begin
                    if (in_frame_reg)
                    begin
                        in_frame_next   = 1'b0;
                        counter_next    = counter_reg + 32'd1;
                        push            = 1'b1;
                        push_data.count = counter_reg + 32'd1;
                        if (emit_frames && (fill_reg != '0))
                        begin
                            push_data.kind = dsed_pkg::KIND_BYTE;
                            busy_next      = 1'b1;
                        end
                    end
                end
                else if (!is_dle)
                begin
                    // drop the frame on an unknown escape
                    in_frame_next = 1'b0;
                end
                else
                begin
                    body = 1'b1;
                end
            end
            else
            begin
                body = 1'b1;
            end

            if (body && in_frame_reg)
            begin
                if (fill_reg < FILL_W'(FRAME_DEPTH))
                begin
                    store_we  = 1'b1;
                    fill_next = fill_reg + FILL_W'(1);
                end
                else
                begin
                    in_frame_next    = 1'b0;
                    push             = 1'b1;
                    push_data.kind   = dsed_pkg::KIND_OVERFLOW;
                    push_data.length = dsed_pkg::LEN_W'(FRAME_DEPTH);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg      <= 1'b0;
            in_frame_reg <= 1'b0;
            fill_reg     <= '0;
            counter_reg  <= '0;
            busy_reg     <= 1'b0;
        end
        else
        begin
            esc_reg      <= esc_next;
            in_frame_reg <= in_frame_next;
            fill_reg     <= fill_next;
            counter_reg  <= counter_next;
            busy_reg     <= busy_next;
        end
    end

endmodule

/* hdl/dsed_cmd_queue.sv */
// ----------------------------------------------------------------------------
// dsed_cmd_queue
// Short FIFO of frame commands between the front and the back.
// ----------------------------------------------------------------------------
module dsed_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dsed_pkg::cmd_t push_data,
    output logic           full,
    output logic           q_valid,
    output dsed_pkg::cmd_t q_data,
    input  logic           pop
);

    dsed_pkg::cmd_t                  entry_reg [dsed_pkg::QUEUE_DEPTH];
    logic [dsed_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [dsed_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [dsed_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;
    logic                            do_push;
    logic                            do_pop;

    assign full    = (cnt_reg == dsed_pkg::QCNT_W'(dsed_pkg::QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + dsed_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + dsed_pkg::QPTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + dsed_pkg::QCNT_W'(1);
            2'b01:   cnt_next = cnt_reg - dsed_pkg::QCNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* hdl/dsed_back.sv */
// ----------------------------------------------------------------------------
// dsed_back
// Holds the frame store, pops commands and drives the result register:
// one result per end or overflow command, the stored bytes for a frame.
// ----------------------------------------------------------------------------
module dsed_back #(
    parameter int FRAME_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           store_we,
    input  logic [$clog2(FRAME_DEPTH)-1:0] store_addr,
    input  logic [7:0]                     store_data,
    input  logic                           q_valid,
    input  dsed_pkg::cmd_t                 q_data,
    output logic                           pop,
    output logic                           frame_done,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     result_kind,
    output logic [7:0]                     frame_byte,
    output logic [3:0]                     byte_index,
    output logic [4:0]                     frame_length,
    output logic                           last,
    output logic [31:0]                    frames_received
);

    localparam int AW = $clog2(FRAME_DEPTH);

    logic [7:0] mem [FRAME_DEPTH];

    dsed_pkg::back_state_t         state_reg, state_next;
    logic [dsed_pkg::LEN_W-1:0]    idx_reg, idx_next;
    logic [dsed_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [31:0]                   cnt_reg, cnt_next;
    logic [7:0]                    rd_data_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [1:0]                    kind_reg, kind_next;
    logic [7:0]                    byte_reg, byte_next;
    logic [3:0]                    bidx_reg, bidx_next;
    logic [4:0]                    flen_reg, flen_next;
    logic                          last_reg, last_next;
    logic [31:0]                   frames_reg, frames_next;
    logic                          out_free;
    logic                          is_last;

    assign out_free = !out_valid_reg || out_ready;
    assign is_last  = ((idx_reg + dsed_pkg::LEN_W'(1)) == len_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        bidx_next      = bidx_reg;
        flen_next      = flen_reg;
        last_next      = last_reg;
        frames_next    = frames_reg;
        pop            = 1'b0;
        frame_done     = 1'b0;

        case (state_reg)
            dsed_pkg::ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    pop = 1'b1;
                    if (q_data.kind == dsed_pkg::KIND_BYTE)
                    begin
                        len_next   = q_data.length;
                        cnt_next   = q_data.count;
                        idx_next   = '0;
                        state_next = dsed_pkg::ST_FETCH;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = q_data.kind;
                        byte_next      = '0;
                        bidx_next      = '0;
                        flen_next      = q_data.length[4:0];
                        last_next      = 1'b1;
                        frames_next    = q_data.count;
                    end
                end
            end
            dsed_pkg::ST_FETCH:
            begin
                state_next = dsed_pkg::ST_SEND;
            end
            dsed_pkg::ST_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = dsed_pkg::KIND_BYTE;
                    byte_next      = rd_data_reg;
                    bidx_next      = idx_reg[3:0];
                    flen_next      = len_reg[4:0];
                    last_next      = is_last;
                    frames_next    = cnt_reg;
                    if (is_last)
                    begin
                        frame_done = 1'b1;
                        state_next = dsed_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + dsed_pkg::LEN_W'(1);
                        state_next = dsed_pkg::ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = dsed_pkg::ST_IDLE;
            end
        endcase
    end

    // Frame store: write from the front, registered read for the drain
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            mem[store_addr] <= store_data;
        end
        if (state_reg == dsed_pkg::ST_FETCH)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsed_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        len_reg    <= len_next;
        cnt_reg    <= cnt_next;
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        bidx_reg   <= bidx_next;
        flen_reg   <= flen_next;
        last_reg   <= last_next;
        frames_reg <= frames_next;
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign frame_byte      = byte_reg;
    assign byte_index      = bidx_reg;
    assign frame_length    = flen_reg;
    assign last            = last_reg;
    assign frames_received = frames_reg;

endmodule

/* tb/dle_stx_etx_deframer_tb.sv */
// ----------------------------------------------------------------------------
// dle_stx_etx_deframer_tb
// Self-checking testbench for the DLE/STX/ETX deframer.
// ----------------------------------------------------------------------------
// Feeds link bytes over the valid/ready input channel and checks every result
// word against an in-bench predictor of the deframer. The run starts with a
// short directed sequence (bytes outside a frame, a stray close, an empty
// frame, a restart, doubled DLE and an unknown escape). Random phases follow,
// mostly well-formed stuffed frames with random content and lengths up to and
// past the store depth, mixed with line noise and broken frames. Between
// phases the emit_frames register is rewritten while the block is idle. Both
// channels insert random wait cycles, with some phases running at full rate.
// ----------------------------------------------------------------------------
module dle_stx_etx_deframer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int PHASES       = 6;
    localparam int PHASE_BYTES  = 60;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;

    // One result word as it leaves the block
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [3:0]  index;
        logic [4:0]  length;
        logic        fin;
        logic [31:0] count;
    } deframed_word_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        emit_frames_we = 1'b0;
    logic        emit_frames    = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte        = 8'h00;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  frame_byte;
    logic [3:0]  byte_index;
    logic [4:0]  frame_length;
    logic        last;
    logic [31:0] frames_received;

    // Link bytes still to be sent, and result words still to arrive
    logic [7:0]     link_bytes[$];
    deframed_word_t awaited_results[$];

    // Predictor copy of the deframer state and its register
    logic        esc_seen    = 1'b0;
    logic        frame_open  = 1'b0;
    logic [4:0]  body_count  = '0;
    logic [7:0]  body_mem[DEPTH];
    logic [31:0] frame_total = '0;
    logic        emit_cfg    = 1'b0;

    logic        idle_on      = 1'b1;
    int unsigned send_gap     = 0;
    int unsigned sink_gap     = 0;
    int unsigned sink_draw    = 0;
    int unsigned stall_cycles = 0;
    int unsigned mismatches   = 0;

    dle_stx_etx_deframer #(
        .FRAME_DEPTH (DEPTH)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .emit_frames_we  (emit_frames_we),
        .emit_frames     (emit_frames),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_byte         (in_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .frame_byte      (frame_byte),
        .byte_index      (byte_index),
        .frame_length    (frame_length),
        .last            (last),
        .frames_received (frames_received)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advance the predicted deframer by one link byte and queue the result
    // words it gives rise to.
    function automatic void deframe_byte(input logic [7:0] b);
        int i;
        if (b == dsed_pkg::SYM_DLE && !esc_seen)
        begin
            esc_seen = 1'b1;
            return;
        end
        if (esc_seen)
        begin
            esc_seen = 1'b0;
            if (b == dsed_pkg::SYM_STX)
            begin
                // open a frame, or restart one and drop what it held
                frame_open = 1'b1;
                body_count = '0;
                return;
            end
            if (b == dsed_pkg::SYM_ETX)
            begin
                // a close with no open frame leaves everything as it is
                if (!frame_open)
                    return;
                frame_open  = 1'b0;
                frame_total = frame_total + 1;
                if (emit_cfg && body_count != 0)
                begin
                    for (i = 0; i < body_count; i++)
                        awaited_results.push_back('{dsed_pkg::KIND_BYTE, body_mem[i],
                                                    4'(i), body_count,
                                                    1'(i + 1 == body_count),
                                                    frame_total});
                end
                else
                    awaited_results.push_back('{dsed_pkg::KIND_END, 8'h00, 4'd0,
                                                body_count, 1'b1, frame_total});
                return;
            end
            if (b != dsed_pkg::SYM_DLE)
            begin
                // unknown escape: drop the frame silently
                frame_open = 1'b0;
                return;
            end
            // doubled DLE falls through as a literal body byte
        end
        if (frame_open)
        begin
            if (body_count < DEPTH)
            begin
                body_mem[body_count[3:0]] = b;
                body_count = body_count + 1;
            end
            else
            begin
                frame_open = 1'b0;
                awaited_results.push_back('{dsed_pkg::KIND_OVERFLOW, 8'h00, 4'd0,
                                            5'(DEPTH), 1'b1, frame_total});
            end
        end
    endfunction

    // Compare one received word with the oldest expected word.
    function automatic void check_result(input deframed_word_t got);
        deframed_word_t want;
        if (awaited_results.size() == 0)
        begin
            $error("unexpected result word: kind %0d byte %02h", got.kind, got.data);
            mismatches++;
            return;
        end
        want = awaited_results.pop_front();
        if (got.kind !== want.kind)
        begin
            $error("result_kind: expected %0d, actual %0d", want.kind, got.kind);
            mismatches++;
        end
        if (got.data !== want.data)
        begin
            $error("frame_byte: expected %02h, actual %02h", want.data, got.data);
            mismatches++;
        end
        if (got.index !== want.index)
        begin
            $error("byte_index: expected %0d, actual %0d", want.index, got.index);
            mismatches++;
        end
        if (got.length !== want.length)
        begin
            $error("frame_length: expected %0d, actual %0d", want.length, got.length);
            mismatches++;
        end
        if (got.fin !== want.fin)
        begin
            $error("last: expected %0d, actual %0d", want.fin, got.fin);
            mismatches++;
        end
        if (got.count !== want.count)
        begin
            $error("frames_received: expected %0d, actual %0d", want.count, got.count);
            mismatches++;
        end
    endfunction

    // Input driver: predict each accepted word, then present the next byte
    // once its drawn wait has run out. Hold the byte until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                deframe_byte(in_byte);
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (link_bytes.size() != 0)
                begin
                    in_byte  <= link_bytes.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= idle_on ? $urandom_range(0, 3) : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each accepted word, then drop ready for a drawn
    // number of cycles before taking the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_gap  <= 0;
        end
        else if (out_valid && out_ready)
        begin
            check_result('{result_kind, frame_byte, byte_index, frame_length, last,
                           frames_received});
            sink_draw = idle_on ? $urandom_range(0, 3) : 0;
            out_ready <= (sink_draw == 0);
            sink_gap  <= (sink_draw == 0) ? 0 : sink_draw - 1;
        end
        else if (!out_ready)
        begin
            if (sink_gap == 0)
                out_ready <= 1'b1;
            else
                sink_gap <= sink_gap - 1;
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Wait until every byte is sent and every expected word has arrived,
    // then let the block settle.
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (link_bytes.size() != 0 || in_valid || awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write emit_frames; only called while the block is idle.
    task automatic apply_emit_setting(input logic v);
        @(posedge clk);
        emit_frames_we <= 1'b1;
        emit_frames    <= v;
        emit_cfg = v;
        @(posedge clk);
        emit_frames_we <= 1'b0;
    endtask

    initial
    begin
        int unsigned ph;
        int unsigned body_len;
        int unsigned k;
        logic [7:0]  b;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        apply_emit_setting(1'b1);

        // Directed: noise outside a frame, stray close, empty frame, restart
        // followed by a frame holding 00, FF and a doubled DLE, unknown escape.
        link_bytes = '{8'h55,
                       dsed_pkg::SYM_DLE, dsed_pkg::SYM_ETX,
                       dsed_pkg::SYM_DLE, dsed_pkg::SYM_STX,
                       dsed_pkg::SYM_DLE, dsed_pkg::SYM_ETX,
                       dsed_pkg::SYM_DLE, dsed_pkg::SYM_STX, 8'hAA,
                       dsed_pkg::SYM_DLE, dsed_pkg::SYM_STX,
                       8'h00, 8'hFF, dsed_pkg::SYM_DLE, dsed_pkg::SYM_DLE,
                       dsed_pkg::SYM_DLE, dsed_pkg::SYM_ETX,
                       dsed_pkg::SYM_DLE, dsed_pkg::SYM_STX, 8'h5A,
                       dsed_pkg::SYM_DLE, 8'h41};

        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_quiet();
            apply_emit_setting(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
            // every third phase runs both channels at full rate
            idle_on = (ph % 3) != 2;
            while (link_bytes.size() < PHASE_BYTES)
            begin
                case ($urandom_range(0, 9))
                    0:
                        repeat ($urandom_range(1, 3))
                            link_bytes.push_back(8'($urandom_range(0, 255)));
                    1:
                        link_bytes = {link_bytes, dsed_pkg::SYM_DLE, dsed_pkg::SYM_ETX};
                    default:
                    begin
                        // stuffed frame, now and then long enough to overflow
                        body_len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 19)
                                                               : $urandom_range(0, 16);
                        link_bytes = {link_bytes, dsed_pkg::SYM_DLE, dsed_pkg::SYM_STX};
                        for (k = 0; k < body_len; k++)
                        begin
                            case ($urandom_range(0, 7))
                                0:       b = dsed_pkg::SYM_DLE;
                                1:       b = dsed_pkg::SYM_STX;
                                2:       b = dsed_pkg::SYM_ETX;
                                default: b = 8'($urandom_range(0, 255));
                            endcase
                            link_bytes.push_back(b);
                            if (b == dsed_pkg::SYM_DLE)
                                link_bytes.push_back(dsed_pkg::SYM_DLE);
                            // break the frame: restart or unknown escape
                            if ($urandom_range(0, 49) == 0)
                                link_bytes = {link_bytes, dsed_pkg::SYM_DLE,
                                              $urandom_range(0, 1) ? dsed_pkg::SYM_STX
                                                                   : 8'hC3};
                        end
                        // leave a few frames without their close
                        if ($urandom_range(0, 9) != 0)
                            link_bytes = {link_bytes, dsed_pkg::SYM_DLE,
                                          dsed_pkg::SYM_ETX};
                    end
                endcase
            end
        end

        wait_quiet();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
hdl/dsed_pkg.sv
hdl/dsed_front.sv
hdl/dsed_cmd_queue.sv
hdl/dsed_back.sv
hdl/dle_stx_etx_deframer.sv
tb/dle_stx_etx_deframer_tb.sv
